// ----- rtl/core/assert_macros.svh -----
// assertion macros included by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define ASSERT_CLK(lbl, clk, rst, prop)

`define ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ----- rtl/core/esc_bdh_pkg.sv -----
// types, codes and helpers for the esc bus discovery handshake unit
package esc_bdh_pkg;

  localparam logic [7:0] ESC_CLASS_MASK = 8'hF0;
  localparam logic [7:0] BROADCAST_TX_ID = 8'hFF;
  localparam logic [7:0] BROADCAST_RX_ID = 8'h00;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_DEVICE_ID = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_HIGH_BAUD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ESC_CLASS_ID = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GUARD_MS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_MS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TELEMETRY_TIMEOUT_MS = 3'd5;

  localparam logic [2:0] PHASE_CODE_DISABLED = 3'd0;
  localparam logic [2:0] PHASE_CODE_GUARD = 3'd1;
  localparam logic [2:0] PHASE_CODE_PWM = 3'd2;
  localparam logic [2:0] PHASE_CODE_SEND_DIRECTED = 3'd3;
  localparam logic [2:0] PHASE_CODE_WAIT_REPLY = 3'd4;
  localparam logic [2:0] PHASE_CODE_SEND_FINAL = 3'd5;
  localparam logic [2:0] PHASE_CODE_WAIT_TX = 3'd6;
  localparam logic [2:0] PHASE_CODE_RUNNING = 3'd7;

  typedef enum logic [2:0] {
    OP_RESTART   = 3'd0,
    OP_DISABLE   = 3'd1,
    OP_HANDSHAKE = 3'd2,
    OP_POLL      = 3'd3,
    OP_TX_DONE   = 3'd4,
    OP_TELEMETRY = 3'd5
  } op_t;

  typedef enum logic [7:0] {
    PH_DISABLED      = 8'b0000_0001,
    PH_GUARD         = 8'b0000_0010,
    PH_PWM           = 8'b0000_0100,
    PH_SEND_DIRECTED = 8'b0000_1000,
    PH_WAIT_REPLY    = 8'b0001_0000,
    PH_SEND_FINAL    = 8'b0010_0000,
    PH_WAIT_TX       = 8'b0100_0000,
    PH_RUNNING       = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [7:0]  own_device_id;
    logic        local_high_baud;
    logic [7:0]  esc_class_id;
    logic [15:0] guard_ms;
    logic [15:0] retry_ms;
    logic [15:0] telemetry_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] now_ms;
    logic        hs_valid;
    logic [7:0]  hs_source_id;
    logic [7:0]  hs_dest_id;
    logic        hs_high_baud;
    logic        tx_space_ok;
  } event_t;

  typedef struct packed {
    logic       frame_accepted;
    logic       send_handshake;
    logic [7:0] send_dest_id;
    logic       send_high_baud;
    logic [2:0] phase;
    logic       link_running;
    logic       baud_is_high;
    logic       telemetry_fresh;
    logic [7:0] esc_id;
  } result_t;

  function automatic logic [2:0] phase_code(input phase_t ph);
    logic [2:0] code;
    case (ph)
      PH_DISABLED:      code = PHASE_CODE_DISABLED;
      PH_GUARD:         code = PHASE_CODE_GUARD;
      PH_PWM:           code = PHASE_CODE_PWM;
      PH_SEND_DIRECTED: code = PHASE_CODE_SEND_DIRECTED;
      PH_WAIT_REPLY:    code = PHASE_CODE_WAIT_REPLY;
      PH_SEND_FINAL:    code = PHASE_CODE_SEND_FINAL;
      PH_WAIT_TX:       code = PHASE_CODE_WAIT_TX;
      PH_RUNNING:       code = PHASE_CODE_RUNNING;
      default:          code = PHASE_CODE_DISABLED;
    endcase
    return code;
  endfunction

endpackage

// ----- rtl/core/esc_bdh_cfg_regs.sv -----
// configuration register file of the esc bus discovery handshake unit
module esc_bdh_cfg_regs
  import esc_bdh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  we,
  input  logic [CFG_IDX_W-1:0]  index,
  input  logic [CFG_DATA_W-1:0] data,
  output cfg_t                  cfg
);

  cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.own_device_id <= 8'd16;
      regs.local_high_baud <= 1'b0;
      regs.esc_class_id <= 8'd64;
      regs.guard_ms <= 16'd50;
      regs.retry_ms <= 16'd50;
      regs.telemetry_timeout_ms <= 16'd500;
    end else if (we) begin
      case (index)
        CFG_OWN_DEVICE_ID:        regs.own_device_id <= data[7:0];
        CFG_LOCAL_HIGH_BAUD:      regs.local_high_baud <= data[0];
        CFG_ESC_CLASS_ID:         regs.esc_class_id <= data[7:0];
        CFG_GUARD_MS:             regs.guard_ms <= data;
        CFG_RETRY_MS:             regs.retry_ms <= data;
        CFG_TELEMETRY_TIMEOUT_MS: regs.telemetry_timeout_ms <= data;
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

// ----- rtl/core/esc_bdh_seq.sv -----
// discovery and handshake sequence state with its next-state and result logic
module esc_bdh_seq
  import esc_bdh_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  event_t  ev,
  input  logic    fire,
  output result_t res
);

  phase_t      phase, phase_next;
  logic [31:0] phase_start_ms, phase_start_ms_next;
  logic [31:0] last_handshake_tx_ms, last_handshake_tx_ms_next;
  logic [31:0] last_telemetry_ms, last_telemetry_ms_next;
  logic [7:0]  found_esc_id, found_esc_id_next;
  logic        esc_high_baud, esc_high_baud_next;
  logic        telemetry_seen, telemetry_seen_next;
  logic        high_baud_active, high_baud_active_next;

  logic [31:0] guard_age;
  logic [31:0] retry_age;
  logic [31:0] telemetry_age;
  logic        guard_expired;
  logic        retry_expired;
  logic        src_is_esc;
  logic        hs_allowed;
  logic        accepted;
  logic        send;
  logic [7:0]  dest;
  logic        shb;

  assign guard_age = ev.now_ms - phase_start_ms;
  assign retry_age = ev.now_ms - last_handshake_tx_ms;
  assign guard_expired = guard_age >= {16'd0, cfg.guard_ms};
  assign retry_expired = retry_age >= {16'd0, cfg.retry_ms};
  assign src_is_esc = (ev.hs_source_id & ESC_CLASS_MASK) == cfg.esc_class_id;
  assign hs_allowed = (phase != PH_DISABLED) && (phase != PH_PWM) && ev.hs_valid && src_is_esc;

  always_comb begin
    phase_next = phase;
    phase_start_ms_next = phase_start_ms;
    last_handshake_tx_ms_next = last_handshake_tx_ms;
    last_telemetry_ms_next = last_telemetry_ms;
    found_esc_id_next = found_esc_id;
    esc_high_baud_next = esc_high_baud;
    telemetry_seen_next = telemetry_seen;
    high_baud_active_next = high_baud_active;
    accepted = 1'b0;
    send = 1'b0;
    dest = 8'd0;
    shb = 1'b0;
    case (ev.op)
      OP_RESTART: begin
        phase_next = PH_GUARD;
        phase_start_ms_next = ev.now_ms;
        last_handshake_tx_ms_next = 32'd0;
        last_telemetry_ms_next = 32'd0;
        high_baud_active_next = 1'b0;
        found_esc_id_next = 8'd0;
        esc_high_baud_next = 1'b0;
        telemetry_seen_next = 1'b0;
      end
      OP_DISABLE: begin
        phase_next = PH_DISABLED;
        telemetry_seen_next = 1'b0;
      end
      OP_HANDSHAKE: begin
        if (hs_allowed) begin
          if (ev.hs_dest_id == BROADCAST_RX_ID) begin
            found_esc_id_next = ev.hs_source_id;
            esc_high_baud_next = ev.hs_high_baud;
            high_baud_active_next = 1'b0;
            phase_next = PH_SEND_DIRECTED;
            phase_start_ms_next = ev.now_ms;
            telemetry_seen_next = 1'b0;
            accepted = 1'b1;
          end else if (ev.hs_dest_id == cfg.own_device_id &&
                       ev.hs_source_id == found_esc_id &&
                       (phase == PH_SEND_DIRECTED || phase == PH_WAIT_REPLY)) begin
            esc_high_baud_next = ev.hs_high_baud;
            phase_next = PH_SEND_FINAL;
            phase_start_ms_next = ev.now_ms;
            accepted = 1'b1;
          end
        end
      end
      OP_POLL: begin
        case (phase)
          PH_GUARD: begin
            if (guard_expired) begin
              phase_next = PH_PWM;
            end
          end
          PH_SEND_DIRECTED, PH_WAIT_REPLY: begin
            if (phase == PH_SEND_DIRECTED || retry_expired) begin
              if (ev.tx_space_ok) begin
                send = 1'b1;
                dest = found_esc_id;
                shb = cfg.local_high_baud;
                last_handshake_tx_ms_next = ev.now_ms;
                phase_next = PH_WAIT_REPLY;
                phase_start_ms_next = ev.now_ms;
              end else begin
                phase_next = PH_SEND_DIRECTED;
              end
            end
          end
          PH_SEND_FINAL: begin
            if (ev.tx_space_ok) begin
              send = 1'b1;
              dest = BROADCAST_TX_ID;
              shb = cfg.local_high_baud & esc_high_baud;
              phase_next = PH_WAIT_TX;
              phase_start_ms_next = ev.now_ms;
            end
          end
          default: ;
        endcase
      end
      OP_TX_DONE: begin
        if (phase == PH_WAIT_TX) begin
          high_baud_active_next = cfg.local_high_baud & esc_high_baud;
          phase_next = PH_RUNNING;
          phase_start_ms_next = ev.now_ms;
          telemetry_seen_next = 1'b0;
        end
      end
      OP_TELEMETRY: begin
        if (phase == PH_RUNNING) begin
          last_telemetry_ms_next = ev.now_ms;
          telemetry_seen_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign telemetry_age = ev.now_ms - last_telemetry_ms_next;

  always_comb begin
    res.frame_accepted = accepted;
    res.send_handshake = send;
    res.send_dest_id = dest;
    res.send_high_baud = shb;
    res.phase = phase_code(phase_next);
    res.link_running = phase_next == PH_RUNNING;
    res.baud_is_high = high_baud_active_next;
    res.telemetry_fresh = (phase_next == PH_RUNNING) && telemetry_seen_next &&
                          (telemetry_age <= {16'd0, cfg.telemetry_timeout_ms});
    res.esc_id = found_esc_id_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_DISABLED;
      phase_start_ms <= 32'd0;
      last_handshake_tx_ms <= 32'd0;
      last_telemetry_ms <= 32'd0;
      found_esc_id <= 8'd0;
      esc_high_baud <= 1'b0;
      telemetry_seen <= 1'b0;
      high_baud_active <= 1'b0;
    end else if (fire) begin
      phase <= phase_next;
      phase_start_ms <= phase_start_ms_next;
      last_handshake_tx_ms <= last_handshake_tx_ms_next;
      last_telemetry_ms <= last_telemetry_ms_next;
      found_esc_id <= found_esc_id_next;
      esc_high_baud <= esc_high_baud_next;
      telemetry_seen <= telemetry_seen_next;
      high_baud_active <= high_baud_active_next;
    end
  end

endmodule

// ----- rtl/core/esc_bus_discovery_handshake_unit.sv -----
// Host-side discovery and handshake sequencer for a motor controller on a shared serial bus.
// One event is taken per clock cycle and each event gives exactly one result: the event
// is held in the input register, where the sequence state is read and updated by a
// single pass of compare and update logic, and its result is then held in the result
// register. The input register refills in the same cycle that it empties, so the rate is
// one event per cycle while the result side takes a transfer every cycle; a stalled result
// holds the input register and then in_stall. Configuration writes are taken whenever the
// input register is empty (cfg_ready high) and are meant for an idle block.
`include "assert_macros.svh"

module esc_bus_discovery_handshake_unit
  import esc_bdh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            op,
  input  logic [31:0]           now_ms,
  input  logic                  hs_valid,
  input  logic [7:0]            hs_source_id,
  input  logic [7:0]            hs_dest_id,
  input  logic                  hs_high_baud,
  input  logic                  tx_space_ok,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  frame_accepted,
  output logic                  send_handshake,
  output logic [7:0]            send_dest_id,
  output logic                  send_high_baud,
  output logic [2:0]            phase,
  output logic                  link_running,
  output logic                  baud_is_high,
  output logic                  telemetry_fresh,
  output logic [7:0]            esc_id,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  event_t  ev;
  result_t res;
  result_t res_q;
  logic    ev_valid;
  logic    in_fire;
  logic    ev_fire;
  logic    cfg_we;

  assign ev_fire = ev_valid && (!out_valid || !out_stall);
  assign in_stall = ev_valid && !ev_fire;
  assign in_fire = in_valid && !in_stall;
  assign cfg_ready = !ev_valid;
  assign cfg_we = cfg_valid && cfg_ready;

  esc_bdh_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  esc_bdh_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .ev   (ev),
    .fire (ev_fire),
    .res  (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (in_fire) begin
      ev_valid <= 1'b1;
    end else if (ev_fire) begin
      ev_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ev.op <= op;
      ev.now_ms <= now_ms;
      ev.hs_valid <= hs_valid;
      ev.hs_source_id <= hs_source_id;
      ev.hs_dest_id <= hs_dest_id;
      ev.hs_high_baud <= hs_high_baud;
      ev.tx_space_ok <= tx_space_ok;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ev_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_fire) begin
      res_q <= res;
    end
  end

  assign frame_accepted = res_q.frame_accepted;
  assign send_handshake = res_q.send_handshake;
  assign send_dest_id = res_q.send_dest_id;
  assign send_high_baud = res_q.send_high_baud;
  assign phase = res_q.phase;
  assign link_running = res_q.link_running;
  assign baud_is_high = res_q.baud_is_high;
  assign telemetry_fresh = res_q.telemetry_fresh;
  assign esc_id = res_q.esc_id;

  `ASSERT_CLK(a_ev_held, clk, rst, ev_valid && !ev_fire |=> ev_valid && $stable(ev))
  `ASSERT_CLK(a_stall_only_full, clk, rst, in_stall |-> ev_valid && out_valid && out_stall)
  `ASSERT_CLK(a_no_send_zero, clk, rst,
              out_valid && !send_handshake |-> send_dest_id == 8'd0 && !send_high_baud)
  `ASSERT_CLK(a_fresh_running, clk, rst, out_valid && telemetry_fresh |-> link_running)
  `ASSERT_ALWAYS(a_reset_clears, clk, $past(rst) |-> !out_valid && !ev_valid)

endmodule
